[rtl/cached_nearest_palette_mapper_unit_macros.svh]
// assertion macros shared by the checker
`ifndef CACHED_NEAREST_PALETTE_MAPPER_UNIT_MACROS_SVH
`define CACHED_NEAREST_PALETTE_MAPPER_UNIT_MACROS_SVH

// consequent in the same cycle
`define CNPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnpm check failed");

// consequent in the next cycle
`define CNPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnpm check failed");

`endif

[rtl/cnpm_pkg.sv]
package cnpm_pkg;

  localparam int CH_W     = 8;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int KEY_W    = 15;
  localparam int CELL_CH  = 5;
  localparam int SQ_W     = 16;
  localparam int DIST_W   = 18;
  localparam int EPOCH_W  = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CNT_W-1:0] COLOR_COUNT_RST = 9'd256;
  localparam logic [0:0]       REG_COLOR_COUNT = 1'b0;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  typedef struct packed {
    logic take;
    logic pal_we;
    logic cell_calc;
    logic cache_rd;
    logic search_init;
    logic issue;
    logic cache_clr;
    logic cache_fill;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic epoch_last;
    logic hit;
    logic found;
    logic pipe_empty;
  } sts_t;

endpackage

[rtl/cnpm_ctrl.sv]
module cnpm_ctrl #(
  parameter int PALETTE_DEPTH = 256,
  parameter int CACHE_CELLS   = 32768
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic [cnpm_pkg::CNT_W-1:0]         color_count,
  input  cnpm_pkg::sts_t                     sts,
  output cnpm_pkg::cmd_t                     cmd,
  output logic [$clog2(PALETTE_DEPTH)-1:0]   rd_idx,
  output logic [$clog2(CACHE_CELLS)-1:0]     clr_addr
);
  import cnpm_pkg::*;

  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int CI = $clog2(CACHE_CELLS);

  typedef enum logic [2:0] {
    CLEAR, IDLE, CELL, LOOK, CHECK, SEARCH, DRAIN, RESP
  } state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   idx_r, idx_nxt;
  logic [CI-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_lim;
  logic            accept;

  assign cnt_lim  = (color_count > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : color_count;
  assign in_ready = (state_r == IDLE);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign rd_idx   = idx_r;
  assign clr_addr = clr_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      CLEAR: begin
        cmd.cache_clr = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CI'(CACHE_CELLS - 1)) begin
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (in_kind == KIND_MAP) begin
            state_nxt = CELL;
          end else if (sts.slot_ok) begin
            cmd.pal_we = 1'b1;
            if (sts.epoch_last) begin
              clr_nxt   = '0;
              state_nxt = CLEAR;
            end
          end
        end
      end
      CELL: begin
        cmd.cell_calc = 1'b1;
        state_nxt = LOOK;
      end
      LOOK: begin
        cmd.cache_rd = 1'b1;
        state_nxt = CHECK;
      end
      CHECK: begin
        if (sts.hit) begin
          state_nxt = RESP;
        end else begin
          cmd.search_init = 1'b1;
          idx_nxt = PW'(cnt_lim - 1'b1);
          state_nxt = (cnt_lim == '0) ? DRAIN : SEARCH;
        end
      end
      SEARCH: begin
        cmd.issue = 1'b1;
        idx_nxt = idx_r - 1'b1;
        if (sts.found || idx_r == '0) begin
          state_nxt = DRAIN;
        end
      end
      DRAIN: begin
        if (sts.pipe_empty) begin
          cmd.cache_fill = 1'b1;
          state_nxt = RESP;
        end
      end
      RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CLEAR;
      idx_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/cnpm_dpath.sv]
module cnpm_dpath #(
  parameter int PALETTE_DEPTH = 256,
  parameter int CACHE_CELLS   = 32768
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [cnpm_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [cnpm_pkg::CH_W-1:0]          in_red,
  input  logic [cnpm_pkg::CH_W-1:0]          in_green,
  input  logic [cnpm_pkg::CH_W-1:0]          in_blue,
  input  cnpm_pkg::cmd_t                     cmd,
  input  logic [$clog2(PALETTE_DEPTH)-1:0]   rd_idx,
  input  logic [$clog2(CACHE_CELLS)-1:0]     clr_addr,
  output cnpm_pkg::sts_t                     sts,
  output logic [cnpm_pkg::IDX_W-1:0]         out_palette_index,
  output logic                               out_cache_hit
);
  import cnpm_pkg::*;

  localparam int PW    = $clog2(PALETTE_DEPTH);
  localparam int CI    = $clog2(CACHE_CELLS);
  localparam int STEPS = KEY_W - CI + 1;
  localparam int CEW   = 1 + EPOCH_W + IDX_W;
  localparam int PEW   = 3 * CH_W;

  logic [PEW-1:0]     pal_mem [PALETTE_DEPTH];
  logic [CEW-1:0]     cache_mem [CACHE_CELLS];

  logic [CH_W-1:0]    red_r, green_r, blue_r;
  logic [KEY_W-1:0]   key_r;
  logic [CI-1:0]      cell_r;
  logic [KEY_W-1:0]   rem;
  logic [EPOCH_W-1:0] epoch_r;
  logic [CEW-1:0]     cq_r;
  logic [PEW-1:0]     pq_r;
  logic               v1_r, v2_r;
  logic [PW-1:0]      idx1_r, idx2_r;
  logic [SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [PW-1:0]      best_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic               found_r;
  logic [DIST_W-1:0]  dist_sum;
  logic [CH_W-1:0]    dr, dg, db;
  logic               hit;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_hit_r;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // cell index: key reduced by the cache size, one compare-subtract per quotient bit
  always_comb begin
    rem = key_r;
    for (int i = STEPS - 1; i >= 0; i--) begin
      if (32'(rem) >= (32'(CACHE_CELLS) << i)) begin
        rem = rem - KEY_W'(32'(CACHE_CELLS) << i);
      end
    end
  end

  assign dr   = abs_diff(pq_r[3*CH_W-1:2*CH_W], red_r);
  assign dg   = abs_diff(pq_r[2*CH_W-1:CH_W], green_r);
  assign db   = abs_diff(pq_r[CH_W-1:0], blue_r);
  assign dist_sum = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  assign hit  = cq_r[CEW-1] && (cq_r[CEW-2:IDX_W] == epoch_r);

  assign sts.slot_ok    = ({1'b0, in_entry_index} < CNT_W'(PALETTE_DEPTH));
  assign sts.epoch_last = &epoch_r;
  assign sts.hit        = hit;
  assign sts.found      = found_r;
  assign sts.pipe_empty = !v1_r && !v2_r;

  assign out_palette_index = out_idx_r;
  assign out_cache_hit     = out_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.pal_we) begin
      pal_mem[in_entry_index[PW-1:0]] <= {in_red, in_green, in_blue};
    end
    if (cmd.issue) begin
      pq_r <= pal_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cache_clr) begin
      cache_mem[clr_addr] <= '0;
    end else if (cmd.cache_fill) begin
      cache_mem[cell_r] <= {1'b1, epoch_r, IDX_W'(best_r)};
    end
    if (cmd.cache_rd) begin
      cq_r <= cache_mem[cell_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      key_r   <= {in_red[CH_W-1 -: CELL_CH], in_green[CH_W-1 -: CELL_CH],
                  in_blue[CH_W-1 -: CELL_CH]};
    end
    if (cmd.cell_calc) begin
      cell_r <= rem[CI-1:0];
    end
    idx1_r <= rd_idx;
    idx2_r <= idx1_r;
    sq_r_r <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_r <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_r <= SQ_W'(db) * SQ_W'(db);
    if (cmd.out_load) begin
      out_idx_r <= hit ? cq_r[IDX_W-1:0] : IDX_W'(best_r);
      out_hit_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_dist_r <= '1;
    end else begin
      if (cmd.pal_we) begin
        epoch_r <= epoch_r + 1'b1;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.search_init) begin
        found_r     <= 1'b0;
        best_r      <= '0;
        best_dist_r <= '1;
      end else if (v2_r && !found_r && dist_sum <= best_dist_r) begin
        best_r <= idx2_r;
        if (dist_sum == '0) begin
          found_r <= 1'b1;
        end else begin
          best_dist_r <= dist_sum;
        end
      end
    end
  end

endmodule

[rtl/cached_nearest_palette_mapper_unit.sv]
// nearest palette mapper with a cell result cache
// input channel: kind 0 loads palette slot entry_index with red/green/blue,
//   kind 1 maps a pixel; only map items give a result on the output channel
// output channel: palette_index and cache_hit, held in an output register
// cache hit: the item passes the CELL, LOOK and CHECK states to RESP, which loads the result
// cache miss: CHECK, SEARCH over n = min(color_count, PALETTE_DEPTH) entries, DRAIN,
//   RESP; SEARCH is skipped when n is zero; the search reads one palette entry a cycle
//   from the palette ram and stops early on an exact match
// one map item at a time: the next item is taken the cycle after the result is
//   loaded
// loads write the palette ram; every 256th valid load starts a cache clearing pass
// reset: color_count = 256, then a clearing pass over the CACHE_CELLS cells of the
//   cache ram, in_ready stays low during it (register writes still accepted)
// a stalled receiver holds the result; the next item is taken meanwhile, its
//   result waits until the output register frees up
// color_count sits at byte address 0 of the apb port
module cached_nearest_palette_mapper_unit #(
  parameter int PALETTE_DEPTH = 256,
  parameter int CACHE_CELLS   = 32768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [cnpm_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [cnpm_pkg::CH_W-1:0]     in_red,
  input  logic [cnpm_pkg::CH_W-1:0]     in_green,
  input  logic [cnpm_pkg::CH_W-1:0]     in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cnpm_pkg::IDX_W-1:0]    out_palette_index,
  output logic                          out_cache_hit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnpm_pkg::APB_AW-1:0]   paddr,
  input  logic [cnpm_pkg::APB_DW-1:0]   pwdata,
  output logic [cnpm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import cnpm_pkg::*;

  localparam int PW = $clog2(PALETTE_DEPTH);
  localparam int CI = $clog2(CACHE_CELLS);

  logic [CNT_W-1:0] color_count_r;
  cmd_t             cmd;
  sts_t             sts;
  logic [PW-1:0]    rd_idx;
  logic [CI-1:0]    clr_addr;
  logic             sel_cc;

  assign pready = 1'b1;
  assign sel_cc = (paddr[2] == REG_COLOR_COUNT);
  assign prdata = sel_cc ? APB_DW'(color_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= COLOR_COUNT_RST;
    end else if (psel && penable && pwrite && sel_cc) begin
      color_count_r <= pwdata[CNT_W-1:0];
    end
  end

  cnpm_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .CACHE_CELLS  (CACHE_CELLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .color_count(color_count_r),
    .sts        (sts),
    .cmd        (cmd),
    .rd_idx     (rd_idx),
    .clr_addr   (clr_addr)
  );

  cnpm_dpath #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .CACHE_CELLS  (CACHE_CELLS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_entry_index   (in_entry_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .cmd              (cmd),
    .rd_idx           (rd_idx),
    .clr_addr         (clr_addr),
    .sts              (sts),
    .out_palette_index(out_palette_index),
    .out_cache_hit    (out_cache_hit)
  );

endmodule

[rtl/cnpm_chk.sv]
`include "cached_nearest_palette_mapper_unit_macros.svh"

module cnpm_chk #(
  parameter int PALETTE_DEPTH = 256
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cnpm_pkg::IDX_W-1:0]  out_palette_index,
  input logic                        out_cache_hit
);
  import cnpm_pkg::*;

  // stalled result holds
  `CNPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_palette_index) && $stable(out_cache_hit))

  // a map item drops in_ready in the cycle after it is taken
  `CNPM_ASSERT_NEXT(a_map_busy, in_valid && in_ready && in_kind == KIND_MAP, !in_ready)

  // index always within the palette
  `CNPM_ASSERT_NOW(a_idx_range, out_valid,
    {1'b0, out_palette_index} < CNT_W'(PALETTE_DEPTH))

  // clearing pass right after reset
  `CNPM_ASSERT_NOW(a_reset_clear, !$past(rst_n), !in_ready)

endmodule

bind cached_nearest_palette_mapper_unit cnpm_chk #(
  .PALETTE_DEPTH(PALETTE_DEPTH)
) u_cnpm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_palette_index(out_palette_index),
  .out_cache_hit    (out_cache_hit)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cnpm_pkg::*;

  localparam int PALETTE_DEPTH = 256;
  localparam int CACHE_CELLS   = 32768;

  typedef struct {
    logic [IDX_W-1:0] palette_index;
    logic             cache_hit;
  } answer_t;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              in_kind        = KIND_LOAD;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [CH_W-1:0]   in_red         = '0;
  logic [CH_W-1:0]   in_green       = '0;
  logic [CH_W-1:0]   in_blue        = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [IDX_W-1:0]  out_palette_index;
  logic              out_cache_hit;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [APB_AW-1:0] paddr          = '0;
  logic [APB_DW-1:0] pwdata         = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned send_gap_pct = 34;
  int unsigned stall_pct    = 61;
  int          failures     = 0;

  // predicted block state
  logic [23:0]      pal_shadow [PALETTE_DEPTH];
  logic [IDX_W-1:0] cell_index [CACHE_CELLS];
  int unsigned      cell_epoch [CACHE_CELLS];
  int unsigned      load_epoch = 1;
  logic [CNT_W-1:0] count_reg  = COLOR_COUNT_RST;

  answer_t     due_answers [$];
  answer_t     head_answer;
  logic [23:0] recent_pixels [16] = '{default: '0};

  cached_nearest_palette_mapper_unit #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .CACHE_CELLS  (CACHE_CELLS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_index   (in_entry_index),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_palette_index(out_palette_index),
    .out_cache_hit    (out_cache_hit),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [IDX_W-1:0] nearest_entry(input logic [CH_W-1:0] r, g, b);
    int          n, e, dr, dg, db;
    int unsigned d, best_d;
    logic [IDX_W-1:0] best;
    n = (count_reg > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(count_reg);
    best = '0;
    best_d = '1;
    for (e = n - 1; e >= 0; e--) begin
      dr = int'(pal_shadow[e][23:16]) - int'(r);
      dg = int'(pal_shadow[e][15:8]) - int'(g);
      db = int'(pal_shadow[e][7:0]) - int'(b);
      d = dr * dr + dg * dg + db * db;
      if (d <= best_d) begin
        best = IDX_W'(e);
        if (d == 0) break;
        best_d = d;
      end
    end
    return best;
  endfunction

  function automatic void record_item(input logic kind, input logic [IDX_W-1:0] slot,
                                      input logic [CH_W-1:0] r, g, b);
    answer_t     a;
    int unsigned cell_id;
    if (kind == KIND_LOAD) begin
      if (slot < PALETTE_DEPTH) begin
        pal_shadow[slot] = {r, g, b};
        // any palette write drops every cached cell
        load_epoch++;
      end
    end else begin
      cell_id = {r[7:3], g[7:3], b[7:3]} % CACHE_CELLS;
      if (cell_epoch[cell_id] == load_epoch) begin
        a.palette_index = cell_index[cell_id];
        a.cache_hit = 1'b1;
      end else begin
        a.palette_index = nearest_entry(r, g, b);
        a.cache_hit = 1'b0;
        cell_index[cell_id] = a.palette_index;
        cell_epoch[cell_id] = load_epoch;
      end
      due_answers.push_back(a);
    end
  endfunction

  task automatic send_item(input logic kind, input logic [IDX_W-1:0] slot,
                           input logic [CH_W-1:0] r, g, b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= slot;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    record_item(kind, slot, r, g, b);
  endtask

  task automatic map_random_pixels(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_item(KIND_MAP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_color_count(input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_COLOR_COUNT, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    count_reg = value;
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(value)) begin
      note_failure($sformatf("color_count readback: expected %0d, got %0d", value, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_answers.size() == 0) begin
        note_failure($sformatf("unexpected result: palette_index %0d cache_hit %0d",
                               out_palette_index, out_cache_hit));
      end else begin
        head_answer = due_answers.pop_front();
        if (out_palette_index !== head_answer.palette_index ||
            out_cache_hit !== head_answer.cache_hit) begin
          note_failure($sformatf(
            "result mismatch: expected index %0d hit %0d, got index %0d hit %0d",
            head_answer.palette_index, head_answer.cache_hit,
            out_palette_index, out_cache_hit));
        end
      end
    end
  end

  task automatic test_register_access();
    set_color_count(9'd0);
    set_color_count(9'd1);
    set_color_count(9'd255);
    set_color_count(9'd511);
    set_color_count(9'd300);
    set_color_count(9'd256);
  endtask

  task automatic test_directed_cases();
    wait_idle(16);
    set_color_count(9'd4);
    send_item(KIND_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(KIND_LOAD, 8'd1, 8'd255, 8'd255, 8'd255);
    send_item(KIND_LOAD, 8'd2, 8'd255, 8'd255, 8'd255);
    send_item(KIND_LOAD, 8'd3, 8'd128, 8'd128, 8'd128);
    // duplicate exact entries, highest one wins
    send_item(KIND_MAP, 8'($urandom), 8'd255, 8'd255, 8'd255);
    send_item(KIND_MAP, 8'($urandom), 8'd255, 8'd255, 8'd255);
    send_item(KIND_MAP, 8'($urandom), 8'd0, 8'd0, 8'd0);
    // equal distance, lowest index wins
    send_item(KIND_MAP, 8'($urandom), 8'd64, 8'd64, 8'd64);
    // same cell keeps the cached answer; the last pixel falls in a new cell
    send_item(KIND_MAP, 8'($urandom), 8'd71, 8'd71, 8'd71);
    send_item(KIND_MAP, 8'($urandom), 8'd130, 8'd126, 8'd129);
    // empty palette
    wait_idle(16);
    set_color_count(9'd0);
    send_item(KIND_MAP, 8'($urandom), 8'd200, 8'd10, 8'd100);
    // count change leaves the cache alone
    wait_idle(16);
    set_color_count(9'd1);
    send_item(KIND_MAP, 8'($urandom), 8'd200, 8'd10, 8'd100);
    send_item(KIND_MAP, 8'($urandom), 8'd7, 8'd7, 8'd7);
    // palette write drops cached cells
    send_item(KIND_LOAD, 8'd3, 8'd200, 8'd10, 8'd100);
    wait_idle(16);
    set_color_count(9'd4);
    send_item(KIND_MAP, 8'($urandom), 8'd200, 8'd10, 8'd100);
    send_item(KIND_MAP, 8'($urandom), 8'd7, 8'd7, 8'd7);
  endtask

  task automatic test_full_palette();
    int s;
    wait_idle(16);
    set_color_count(9'd256);
    for (s = 0; s < PALETTE_DEPTH; s++) begin
      if (s == 0) begin
        send_item(KIND_LOAD, 8'(s), 8'd0, 8'd0, 8'd0);
      end else if (s == PALETTE_DEPTH - 1) begin
        send_item(KIND_LOAD, 8'(s), 8'd255, 8'd255, 8'd255);
      end else begin
        send_item(KIND_LOAD, 8'(s), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    map_random_pixels(8);
    // count above the palette depth saturates
    wait_idle(16);
    set_color_count(9'd511);
    send_item(KIND_MAP, 8'($urandom), 8'd255, 8'd255, 8'd255);
    map_random_pixels(8);
    wait_idle(16);
    set_color_count(9'd255);
    send_item(KIND_MAP, 8'($urandom), 8'd250, 8'd251, 8'd252);
    map_random_pixels(8);
  endtask

  task automatic test_random_traffic(input int items, input logic [CNT_W-1:0] count,
                                     input int unsigned gap_pct, input int unsigned hold_pct);
    int          i;
    int unsigned roll, live;
    logic [23:0] pix;
    wait_idle(16);
    send_gap_pct = gap_pct;
    stall_pct = hold_pct;
    set_color_count(count);
    live = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;
    for (i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        send_item(KIND_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 36) begin
        // revisit a recent cell with new low bits
        pix = recent_pixels[$urandom_range(15)];
        send_item(KIND_MAP, 8'($urandom), {pix[23:19], 3'($urandom)},
                  {pix[15:11], 3'($urandom)}, {pix[7:3], 3'($urandom)});
      end else if (roll < 50 && live != 0) begin
        pix = pal_shadow[$urandom_range(live - 1)];
        send_item(KIND_MAP, 8'($urandom), pix[23:16], pix[15:8], pix[7:0]);
      end else begin
        pix = 24'($urandom);
        recent_pixels[$urandom_range(15)] = pix;
        send_item(KIND_MAP, 8'($urandom), pix[23:16], pix[15:8], pix[7:0]);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_directed_cases();
    test_full_palette();
    test_random_traffic(500, 9'd256, 34, 61);
    test_random_traffic(500, 9'($urandom_range(2, 255)), 61, 34);
    test_random_traffic(500, 9'd511, 0, 0);
    wait_idle(300);
    if (failures == 0 && due_answers.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/cnpm_pkg.sv
rtl/cnpm_ctrl.sv
rtl/cnpm_dpath.sv
rtl/cached_nearest_palette_mapper_unit.sv
rtl/cnpm_chk.sv
tb/sv/testbench.sv
